### sv/rsqe_pkg.sv
// Package for the reciprocal square root estimate pipeline.
// Holds the estimate ROM tables and special-case constants; no dependencies.
`timescale 1ns / 1ps
package rsqe_pkg;

  localparam logic [63:0] DefaultNan = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] PosInf     = 64'h7FF0_0000_0000_0000;

  function automatic logic [25:0] rsq_base(input logic [4:0] idx);
    logic [25:0] r;
    case (idx)
      5'd0: r = 26'h3ffa000;  5'd1: r = 26'h3c29000;  5'd2: r = 26'h38aa000;
      5'd3: r = 26'h3572000;  5'd4: r = 26'h3279000;  5'd5: r = 26'h2fb7000;
      5'd6: r = 26'h2d26000;  5'd7: r = 26'h2ac0000;  5'd8: r = 26'h2881000;
      5'd9: r = 26'h2665000;  5'd10: r = 26'h2468000; 5'd11: r = 26'h2287000;
      5'd12: r = 26'h20c1000; 5'd13: r = 26'h1f12000; 5'd14: r = 26'h1d79000;
      5'd15: r = 26'h1bf4000; 5'd16: r = 26'h1a7e800; 5'd17: r = 26'h17cb800;
      5'd18: r = 26'h1552800; 5'd19: r = 26'h130c000; 5'd20: r = 26'h10f2000;
      5'd21: r = 26'h0eff000; 5'd22: r = 26'h0d2e000; 5'd23: r = 26'h0b7c000;
      5'd24: r = 26'h09e5000; 5'd25: r = 26'h0867000; 5'd26: r = 26'h06ff000;
      5'd27: r = 26'h05ab800; 5'd28: r = 26'h046a000; 5'd29: r = 26'h0339800;
      5'd30: r = 26'h0218800; default: r = 26'h0105800;
    endcase
    return r;
  endfunction

  function automatic logic [10:0] rsq_dec(input logic [4:0] idx);
    logic [10:0] r;
    case (idx)
      5'd0: r = 11'h7a4;  5'd1: r = 11'h700;  5'd2: r = 11'h670;  5'd3: r = 11'h5f2;
      5'd4: r = 11'h584;  5'd5: r = 11'h524;  5'd6: r = 11'h4cc;  5'd7: r = 11'h47e;
      5'd8: r = 11'h43a;  5'd9: r = 11'h3fa;  5'd10: r = 11'h3c2; 5'd11: r = 11'h38e;
      5'd12: r = 11'h35e; 5'd13: r = 11'h332; 5'd14: r = 11'h30a; 5'd15: r = 11'h2e6;
      5'd16: r = 11'h568; 5'd17: r = 11'h4f3; 5'd18: r = 11'h48d; 5'd19: r = 11'h435;
      5'd20: r = 11'h3e7; 5'd21: r = 11'h3a2; 5'd22: r = 11'h365; 5'd23: r = 11'h32e;
      5'd24: r = 11'h2fc; 5'd25: r = 11'h2d0; 5'd26: r = 11'h2a8; 5'd27: r = 11'h283;
      5'd28: r = 11'h261; 5'd29: r = 11'h243; 5'd30: r = 11'h226; default: r = 11'h20b;
    endcase
    return r;
  endfunction

endpackage

### sv/recip_sqrt_estimate_double.sv
// Top level of the reciprocal square root estimate for IEEE doubles.
// Four-stage pipeline; uses rsqe_pkg for the ROM tables and constants.
//
//   channel   signals                                  direction
//   operand   operand_valid_i/ready_o, operand_bits_i  in
//   estimate  estimate_valid_o/ready_i, estimate_bits_o out
//
// One request enters per cycle while no stall holds operand_ready_o low.
// Stage 1 classifies and counts leading zeros, stage 2 normalizes, stage 3
// reads the ROM and multiplies, stage 4 subtracts and assembles the result.
// Reset clears only the valid bits. A stall freezes each stage that holds
// an item and has no free place ahead, so nothing is lost or repeated.
`timescale 1ns / 1ps
module recip_sqrt_estimate_double
  import rsqe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        operand_valid_i,
  output logic        operand_ready_o,
  input  logic [63:0] operand_bits_i,
  output logic        estimate_valid_o,
  input  logic        estimate_ready_i,
  output logic [63:0] estimate_bits_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || estimate_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign operand_ready_o = en1;

  // Stage 1.
  logic        s1_spec_q;
  logic [63:0] s1_spec_val_q;
  logic [51:0] s1_frac_q;
  logic [10:0] s1_ef_q;
  logic [5:0]  s1_lz_q;
  logic        s1_spec_d;
  logic [63:0] s1_spec_val_d;
  logic [5:0]  lz_d;
  logic [10:0] ef_in;
  logic [51:0] fr_in;

  assign ef_in = operand_bits_i[62:52];
  assign fr_in = operand_bits_i[51:0];

  always_comb begin
    lz_d = 6'd52;
    for (int k = 0; k < 52; k++) begin
      if (fr_in[k]) lz_d = 6'(51 - k);
    end
  end

  always_comb begin
    s1_spec_d = 1'b1;
    s1_spec_val_d = DefaultNan;
    if (ef_in == 11'd0 && fr_in == 52'd0) begin
      s1_spec_val_d = {operand_bits_i[63], PosInf[62:0]};
    end else if (ef_in == 11'h7FF) begin
      if (fr_in == 52'd0) s1_spec_val_d = operand_bits_i[63] ? DefaultNan : 64'd0;
      else s1_spec_val_d = operand_bits_i | 64'h0008_0000_0000_0000;
    end else if (!operand_bits_i[63]) begin
      s1_spec_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= operand_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_spec_q <= s1_spec_d;
      s1_spec_val_q <= s1_spec_val_d;
      s1_frac_q <= fr_in;
      s1_ef_q <= ef_in;
      s1_lz_q <= lz_d;
    end
  end

  // Stage 2: normalize and form the exponent.
  logic        s2_spec_q;
  logic [63:0] s2_spec_val_q;
  logic [14:0] s2_i_q;
  logic        s2_even_q;
  logic [10:0] s2_exp_q;
  logic [52:0] norm;

  assign norm = {1'b0, s1_frac_q} << (s1_lz_q + 6'd1);

  // Denormal: shifts needed = lz + 1, e = 1 - (lz + 1) = -lz.
  logic [11:0] e_den;
  assign e_den = 12'd0 - 12'(s1_lz_q);
  logic [11:0] e_use;
  logic [11:0] d_use;
  logic [11:0] v_top;
  assign e_use = (s1_ef_q == 11'd0) ? e_den : {1'b0, s1_ef_q};
  assign d_use = e_use - 12'h3FE;
  // v bits 62..51 = 0x7FE - d, taken over 12 bits; exponent is bits 11..1.
  assign v_top = 12'h7FE - d_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_spec_q <= s1_spec_q;
      s2_spec_val_q <= s1_spec_val_q;
      s2_i_q <= (s1_ef_q == 11'd0) ? norm[51:37] : s1_frac_q[51:37];
      s2_even_q <= !e_use[0];
      s2_exp_q <= v_top[11:1];
    end
  end

  // Stage 3: ROM and multiply.
  logic        s3_spec_q;
  logic [63:0] s3_spec_val_q;
  logic [10:0] s3_exp_q;
  logic [25:0] s3_base_q;
  logic [21:0] s3_prod_q;
  logic [4:0]  idx;
  assign idx = {s2_even_q, s2_i_q[14:11]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_spec_q <= s2_spec_q;
      s3_spec_val_q <= s2_spec_val_q;
      s3_exp_q <= s2_exp_q;
      s3_base_q <= rsq_base(idx);
      s3_prod_q <= rsq_dec(idx) * s2_i_q[10:0];
    end
  end

  // Stage 4: subtract and assemble.
  logic [63:0] est_q;
  logic [25:0] est;
  assign est = s3_base_q - 26'(s3_prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      est_q <= s3_spec_q ? s3_spec_val_q : {1'b0, s3_exp_q, est, 26'd0};
    end
  end

  assign estimate_valid_o = v4_q;
  assign estimate_bits_o = est_q;

  held_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !estimate_ready_i) |=> (v4_q && $stable(est_q)))
    else $error("held result changed");
  ready_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!operand_ready_o) |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("stall with a free stage");
  pos_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !est_q[63]) |-> (est_q[62:52] != 11'h7FF || est_q[51:0] == 52'd0
      || est_q[51]))
    else $error("NaN result not quiet");

endmodule
